// ----- rtl/tsg_pkg.sv -----
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared widths, command and register codes, and payload types of the
// triangle sweep generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int VOLTAGE_BITS = 24;
  localparam int ELAPSED_BITS = 16;
  localparam int SLEW_BITS    = 16;
  localparam int CNT_BITS     = 8;
  localparam int CMD_BITS     = 2;

  // step amount is elapsed_ms * mV/s, already in uV
  localparam int PROD_BITS = ELAPSED_BITS + SLEW_BITS;
  localparam int SUM_BITS  = ((VOLTAGE_BITS > PROD_BITS) ? VOLTAGE_BITS : PROD_BITS) + 2;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // commands
  localparam logic [CMD_BITS-1:0] CMD_STEP  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_STOP  = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = VOLTAGE_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_V = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_V  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_V  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLEW    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL   = 3'd4;

  typedef struct packed {
    logic signed [VOLTAGE_BITS-1:0] start_voltage_uv;
    logic signed [VOLTAGE_BITS-1:0] peak_voltage_uv;
    logic signed [VOLTAGE_BITS-1:0] stop_voltage_uv;
    logic [SLEW_BITS-1:0]           slew_rate_mv_per_s;
    logic [CNT_BITS-1:0]            total_cycles;
  } cfg_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]     command;
    logic [ELAPSED_BITS-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [VOLTAGE_BITS-1:0] drive_voltage_uv;
    logic [CNT_BITS-1:0]            cycles_done;
    logic                           falling;
    logic                           running;
    logic                           finished;
  } out_item_t;

endpackage

// ----- rtl/tsg_if.sv -----
// ----------------------------------------------------------------------------
// tsg_if
// Valid/ready channels of the triangle sweep generator: command items in,
// sweep results out.
// ----------------------------------------------------------------------------
interface tsg_in_if;
  import tsg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_BITS-1:0]     command;
  logic [ELAPSED_BITS-1:0] elapsed_ms;

  modport source (output valid, output command, output elapsed_ms, input ready);
  modport sink   (input valid, input command, input elapsed_ms, output ready);
endinterface

interface tsg_out_if;
  import tsg_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [VOLTAGE_BITS-1:0] drive_voltage_uv;
  logic [CNT_BITS-1:0]            cycles_done;
  logic                           falling;
  logic                           running;
  logic                           finished;

  modport source (output valid, output drive_voltage_uv, output cycles_done,
                  output falling, output running, output finished, input ready);
  modport sink   (input valid, input drive_voltage_uv, input cycles_done,
                  input falling, input running, input finished, output ready);
endinterface

// ----- rtl/tsg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tsg_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tsg_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tsg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output tsg_pkg::cfg_t                      cfg
);
  import tsg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_V: cfg_r.start_voltage_uv   <= cfg_wdata[VOLTAGE_BITS-1:0];
        REG_PEAK_V:  cfg_r.peak_voltage_uv    <= cfg_wdata[VOLTAGE_BITS-1:0];
        REG_STOP_V:  cfg_r.stop_voltage_uv    <= cfg_wdata[VOLTAGE_BITS-1:0];
        REG_SLEW:    cfg_r.slew_rate_mv_per_s <= cfg_wdata[SLEW_BITS-1:0];
        REG_TOTAL:   cfg_r.total_cycles       <= cfg_wdata[CNT_BITS-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/tsg_step.sv -----
// ----------------------------------------------------------------------------
// tsg_step
// Sweep state and its combinational update: multiply, add, saturate, turn at
// peak, wrap at stop, count cycles, end the run; start and stop commands.
// ----------------------------------------------------------------------------
module tsg_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  tsg_pkg::in_item_t     item,
  input  tsg_pkg::cfg_t         cfg,
  output tsg_pkg::out_item_t    res
);
  import tsg_pkg::*;

  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    {{(SUM_BITS-VOLTAGE_BITS+1){1'b0}}, {(VOLTAGE_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SAT_LO =
    {{(SUM_BITS-VOLTAGE_BITS+1){1'b1}}, {(VOLTAGE_BITS-1){1'b0}}};

  logic signed [VOLTAGE_BITS-1:0] volt_r, volt_nxt;
  logic                           fall_r, fall_nxt;
  logic [CNT_BITS-1:0]            cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           fin;

  logic [PROD_BITS-1:0]           delta;
  logic signed [SUM_BITS-1:0]     volt_ext, delta_ext, sum, clamp;
  logic signed [VOLTAGE_BITS-1:0] sat_v, peak_v, wrap_v;
  logic                           peak_fall, wrap_hit;
  logic [CNT_BITS-1:0]            step_cnt;

  // step datapath
  always_comb begin
    delta     = PROD_BITS'(item.elapsed_ms) * PROD_BITS'(cfg.slew_rate_mv_per_s);
    volt_ext  = {{(SUM_BITS-VOLTAGE_BITS){volt_r[VOLTAGE_BITS-1]}}, volt_r};
    delta_ext = {{(SUM_BITS-PROD_BITS){1'b0}}, delta};
    sum       = fall_r ? (volt_ext - delta_ext) : (volt_ext + delta_ext);
    if (sum > SAT_HI) begin
      clamp = SAT_HI;
    end else if (sum < SAT_LO) begin
      clamp = SAT_LO;
    end else begin
      clamp = sum;
    end
    sat_v = clamp[VOLTAGE_BITS-1:0];

    // rising sweep clamps at the peak and turns
    if (!fall_r && (sat_v >= cfg.peak_voltage_uv)) begin
      peak_v    = cfg.peak_voltage_uv;
      peak_fall = 1'b1;
    end else begin
      peak_v    = sat_v;
      peak_fall = fall_r;
    end

    // falling sweep at or below stop wraps to start, one more cycle done
    wrap_hit = peak_fall && (peak_v <= cfg.stop_voltage_uv);
    wrap_v   = wrap_hit ? cfg.start_voltage_uv : peak_v;
    if (wrap_hit && (cnt_r != CNT_MAX)) begin
      step_cnt = cnt_r + CNT_BITS'(1);
    end else begin
      step_cnt = cnt_r;
    end
  end

  // command decode and next state
  always_comb begin
    volt_nxt = volt_r;
    fall_nxt = fall_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    fin      = 1'b0;
    unique case (item.command)
      CMD_START: begin
        cnt_nxt  = '0;
        fall_nxt = 1'b0;
        if (cfg.total_cycles == '0) begin
          volt_nxt = '0;
          run_nxt  = 1'b0;
          fin      = 1'b1;
        end else begin
          volt_nxt = cfg.start_voltage_uv;
          run_nxt  = 1'b1;
        end
      end
      CMD_STOP: begin
        if (run_r) begin
          volt_nxt = '0;
          run_nxt  = 1'b0;
          fin      = 1'b1;
        end
      end
      CMD_STEP: begin
        if (run_r) begin
          cnt_nxt  = step_cnt;
          fall_nxt = peak_fall && !wrap_hit;
          if (step_cnt >= cfg.total_cycles) begin
            volt_nxt = '0;
            run_nxt  = 1'b0;
            fin      = 1'b1;
          end else begin
            volt_nxt = wrap_v;
          end
        end
      end
      default: ;  // unused code, report state
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r <= '0;
      fall_r <= 1'b0;
      cnt_r  <= '0;
      run_r  <= 1'b0;
    end else if (en) begin
      volt_r <= volt_nxt;
      fall_r <= fall_nxt;
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
    end
  end

  always_comb begin
    res.drive_voltage_uv = run_nxt ? volt_nxt : '0;
    res.cycles_done      = cnt_nxt;
    res.falling          = fall_nxt;
    res.running          = run_nxt;
    res.finished         = fin;
  end

`ifndef SYNTH
  // idle state always holds 0 V
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (volt_r == '0))
    else $error("sweep voltage nonzero while idle");

  // only a start lowers the cycle count
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (item.command != CMD_START)) |=> (cnt_r >= $past(cnt_r)))
    else $error("cycle count went down without a start");

  // a start always leaves the sweep rising
  a_start_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (item.command == CMD_START)) |=> !fall_r)
    else $error("sweep not rising after start");
`endif

endmodule

// ----- rtl/triangle_sweep_generator.sv -----
// ----------------------------------------------------------------------------
// triangle_sweep_generator
// Cyclic-voltammetry triangle sweep: start/step/stop command items in, one
// drive-voltage result per item out.
// ----------------------------------------------------------------------------
// Takes one command item per clock while the output is not stalled and
// returns exactly one result per item, held in the input register and then
// in the result register. The rate is set by the combinational step path in
// tsg_step (16x16 multiply, saturating add and peak/stop compares) sitting
// between the input register and the result register. A stalled result
// register holds one result while the input register holds the next item;
// only when both are full does in_ch.ready drop. Configuration writes are
// registered and must only be made while no item is in flight.
module triangle_sweep_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  tsg_in_if.sink                             in_ch,
  tsg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [tsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tsg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import tsg_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t step_res;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      advance;
  logic      in_xfer;

  // result register is free when empty or being drained this cycle
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  tsg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.command    <= in_ch.command;
      in_item_r.elapsed_ms <= in_ch.elapsed_ms;
    end
  end

  // sweep state moves only when the item moves into the result register
  tsg_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_valid_r && advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_item_r <= step_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.drive_voltage_uv = out_item_r.drive_voltage_uv;
  assign out_ch.cycles_done      = out_item_r.cycles_done;
  assign out_ch.falling          = out_item_r.falling;
  assign out_ch.running          = out_item_r.running;
  assign out_ch.finished         = out_item_r.finished;

`ifndef SYNTH
  // input side only backs up when both registers are full and output stalls
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  // a held item always moves into the result register when it is free
  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance) |=> out_valid_r)
    else $error("item lost between input and result register");

  // nothing offered on the output right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule
